@@ design/msep_pkg.sv @@
// ----------------------------------------------------------------------------
// msep_pkg
// Shared types and constants of the moving interval separation test.
// ----------------------------------------------------------------------------
`default_nettype none

package msep_pkg;

  // Q16.16 value and time widths
  localparam int unsigned QW    = 32;
  localparam int unsigned TimeW = 31;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 160;
  localparam int unsigned OutDataW = 200;

  // Quotient bits resolved one per cycle by the serial divider
  localparam int unsigned DivSteps = 33;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam logic signed [QW-1:0] QMax       = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] QMin       = 32'sh8000_0000;
  localparam logic [TimeW-1:0]     HorizonRst = 31'd1092;

  // Contact side codes (two's complement -1, 0, +1)
  localparam logic [1:0] SideNone  = 2'b00;
  localparam logic [1:0] SideLeft  = 2'b11;
  localparam logic [1:0] SideRight = 2'b01;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIRST,
    ST_HORIZ,
    ST_LAST,
    ST_JUDGE,
    ST_WRITE
  } msep_state_e;

  typedef enum logic [1:0] {
    KIND_LEFT,
    KIND_RIGHT,
    KIND_OVER
  } msep_kind_e;

  typedef struct packed {
    logic                   start;
    logic signed [QW:0]     num;
    logic signed [QW-1:0]   den;
  } msep_div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [QW-1:0]   quot;
  } msep_div_rsp_t;

endpackage

`default_nettype wire

@@ design/msep_div.sv @@
// ----------------------------------------------------------------------------
// msep_div
// Bit-serial signed divider: (num * 65536) / den, truncated toward zero and
// saturated to the signed 32-bit range. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msep_div
  import msep_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  msep_div_req_t req_i,
  output msep_div_rsp_t rsp_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [QW-1:0]      rem_q;
  logic [QW:0]        sh_q;
  logic [QW-1:0]      den_q;
  logic               neg_q;
  logic               ovf_q;
  logic [QW-1:0]      quot_q;

  logic [QW:0]        num_abs;
  logic [QW-1:0]      den_abs;
  logic [QW-1:0]      head;
  logic [QW:0]        trial;
  logic [QW:0]        diff;
  logic               fits;
  logic [QW-1:0]      rem_d;
  logic [QW:0]        neg_mag;
  logic [QW-1:0]      sat;

  assign num_abs = req_i.num[QW] ? ((QW+1)'(0) - req_i.num) : req_i.num;
  assign den_abs = req_i.den[QW-1] ? (QW'(0) - req_i.den) : req_i.den;

  // The scaled dividend is |num| << 16; its bits above the 33 resolved
  // quotient positions form the initial partial remainder.
  assign head = {16'd0, num_abs[QW:17]};

  assign trial = {rem_q, sh_q[QW]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});
  assign rem_d = fits ? diff[QW-1:0] : trial[QW-1:0];

  assign neg_mag = (QW+1)'(0) - sh_q;

  always_comb begin
    if (ovf_q) begin
      sat = neg_q ? QMin : QMax;
    end else if (neg_q) begin
      sat = (sh_q > {1'b0, QMin}) ? QMin : neg_mag[QW-1:0];
    end else begin
      sat = (sh_q > {1'b0, QMax}) ? QMax : sh_q[QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivSteps);
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= head;
      sh_q  <= {num_abs[16:0], 16'd0};
      den_q <= den_abs;
      neg_q <= req_i.num[QW] ^ req_i.den[QW-1];
      ovf_q <= (head >= den_abs);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        rem_q <= rem_d;
        // Quotient bits enter at the bottom as dividend bits leave the top.
        sh_q  <= {sh_q[QW-1:0], fits};
      end else begin
        quot_q <= sat;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

@@ design/moving_interval_separation_test_core.sv @@
// ----------------------------------------------------------------------------
// moving_interval_separation_test_core
// Separating axis test for two moving convex bodies, one axis per item.
// ----------------------------------------------------------------------------
// Each item on the slave stream is one candidate axis: the projected
// intervals of bodies A and B and their relative speed, with tuser set on
// the first axis of a new body pair. Every item yields exactly one result
// item on the master stream holding the separation flag, contact side,
// first and last contact times and the intervals that set first contact.
// The time horizon is to be written by the user over the cfg channel only
// while the block is idle; the block itself does not enforce this. Items
// are handled one at a time. An axis with intervals apart and closing in
// needs two contact times, found by two bit-serial dividers working side by
// side, 33 quotient bits at one bit per cycle; axes that need no division
// skip them. The next item can be taken in the cycle after the result is
// registered. The result register holds its item while m_axis_tready is
// low, and a new result waits in the write state until it is free.
// Reset clears the pair state, sets the last contact time to its maximum and
// restores the horizon to 1092 (about 1/60 in Q16.16).
// ----------------------------------------------------------------------------
`default_nettype none

module moving_interval_separation_test_core
  import msep_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TimeW-1:0]    cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // a_min, a_max, b_min, b_max, axis_speed (32 bits each, lowest first)
  input  logic [InDataW-1:0]  s_axis_tdata,
  // new_pair
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // separated, contact_side, first_time, last_time, hit_a_min, hit_a_max,
  // hit_b_min, hit_b_max, zero padding
  output logic [OutDataW-1:0] m_axis_tdata
);

  msep_state_e state_q, state_d;
  msep_kind_e  kind_q, kind_d;

  logic [TimeW-1:0]     horizon_q;
  logic [TimeW-1:0]     first_q;
  logic signed [QW-1:0] last_q;
  logic [1:0]           side_q;
  logic signed [QW-1:0] hit_q [4];
  logic                 sticky_q;

  logic signed [QW-1:0] a_min_q, a_max_q, b_min_q, b_max_q, spd_q;

  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;

  msep_div_req_t req_first, req_last;
  msep_div_rsp_t rsp_first, rsp_last;

  logic left_w, right_w, spd_neg, spd_zero, spd_pos;
  logic sep_now, hz_over, cross_w, first_gt, last_lt, out_free;
  logic signed [QW:0] num_first, num_last;
  logic signed [QW:0] d_amin_bmin, d_amax_bmin, d_amin_bmax;

  logic accept, clr_pair, start_div, take_first, take_last, set_sticky, out_load;

  // ---------------------------------------------------------------- classify
  assign left_w   = (b_max_q < a_min_q);
  assign right_w  = !left_w && (a_max_q < b_min_q);
  assign spd_neg  = spd_q[QW-1];
  assign spd_zero = (spd_q == '0);
  assign spd_pos  = !spd_neg && !spd_zero;

  // Apart and not closing in: separated without any division.
  assign sep_now = (left_w && !spd_pos) || (right_w && !spd_neg);

  assign d_amin_bmin = {a_min_q[QW-1], a_min_q} - {b_min_q[QW-1], b_min_q};
  assign d_amax_bmin = {a_max_q[QW-1], a_max_q} - {b_min_q[QW-1], b_min_q};
  assign d_amin_bmax = {a_min_q[QW-1], a_min_q} - {b_max_q[QW-1], b_max_q};

  always_comb begin
    num_first = '0;
    num_last  = '0;
    kind_d    = KIND_OVER;
    if (left_w) begin
      num_first = d_amin_bmin;
      num_last  = d_amax_bmin;
      kind_d    = KIND_LEFT;
    end else if (right_w) begin
      num_first = d_amax_bmin;
      num_last  = d_amin_bmax;
      kind_d    = KIND_RIGHT;
    end else begin
      num_last  = spd_pos ? d_amax_bmin : d_amin_bmax;
    end
  end

  assign first_gt = (rsp_first.quot > $signed({1'b0, first_q}));
  assign last_lt  = (rsp_last.quot < last_q);
  assign hz_over  = (first_q > horizon_q);
  assign cross_w  = ($signed({1'b0, first_q}) > last_q);
  assign out_free = !out_valid_q || m_axis_tready;

  // ---------------------------------------------------------------- dividers
  assign req_first.start = start_div;
  assign req_first.num   = num_first;
  assign req_first.den   = spd_q;
  assign req_last.start  = start_div;
  assign req_last.num    = num_last;
  assign req_last.den    = spd_q;

  msep_div u_div_first (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_first),
    .rsp_o  (rsp_first)
  );

  msep_div u_div_last (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_last),
    .rsp_o  (rsp_last)
  );

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_LOAD;
      ST_LOAD: begin
        if (sticky_q || sep_now || (!left_w && !right_w && spd_zero)) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rsp_last.done) state_d = (kind_q == KIND_OVER) ? ST_LAST : ST_FIRST;
      end
      ST_FIRST: state_d = ST_HORIZ;
      ST_HORIZ: state_d = hz_over ? ST_WRITE : ST_LAST;
      ST_LAST:  state_d = ST_JUDGE;
      ST_JUDGE: state_d = ST_WRITE;
      ST_WRITE: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    accept        = 1'b0;
    clr_pair      = 1'b0;
    start_div     = 1'b0;
    take_first    = 1'b0;
    take_last     = 1'b0;
    set_sticky    = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        accept        = s_axis_tvalid;
        clr_pair      = s_axis_tvalid && s_axis_tuser;
      end
      ST_LOAD: begin
        set_sticky = !sticky_q && sep_now;
        start_div  = !sticky_q && !sep_now && !(!left_w && !right_w && spd_zero);
      end
      ST_FIRST: take_first = first_gt;
      ST_HORIZ: set_sticky = hz_over;
      ST_LAST:  take_last  = last_lt;
      ST_JUDGE: set_sticky = cross_w;
      ST_WRITE: out_load   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_OVER;
    end else begin
      state_q <= state_d;
      if (start_div) kind_q <= kind_d;
    end
  end

  // ---------------------------------------------------------------- pair state
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= HorizonRst;
      first_q   <= '0;
      last_q    <= QMax;
      side_q    <= SideNone;
      sticky_q  <= 1'b0;
      for (int k = 0; k < 4; k++) hit_q[k] <= '0;
    end else begin
      if (cfg_valid_i) horizon_q <= cfg_data_i;
      if (clr_pair) begin
        first_q  <= '0;
        last_q   <= QMax;
        side_q   <= SideNone;
        sticky_q <= 1'b0;
        for (int k = 0; k < 4; k++) hit_q[k] <= '0;
      end else begin
        if (set_sticky) sticky_q <= 1'b1;
        if (take_first) begin
          // A quotient above first_q is positive, so its low 31 bits hold it.
          first_q  <= rsp_first.quot[TimeW-1:0];
          side_q   <= (kind_q == KIND_LEFT) ? SideLeft : SideRight;
          hit_q[0] <= a_min_q;
          hit_q[1] <= a_max_q;
          hit_q[2] <= b_min_q;
          hit_q[3] <= b_max_q;
        end
        if (take_last) last_q <= rsp_last.quot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_min_q <= s_axis_tdata[31:0];
      a_max_q <= s_axis_tdata[63:32];
      b_min_q <= s_axis_tdata[95:64];
      b_max_q <= s_axis_tdata[127:96];
      spd_q   <= s_axis_tdata[159:128];
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {6'd0, hit_q[3], hit_q[2], hit_q[1], hit_q[0],
                     last_q, first_q, side_q, sticky_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

@@ design/msep_checker.sv @@
// ----------------------------------------------------------------------------
// msep_checker
// Port-level checks of the moving interval separation test core.
// ----------------------------------------------------------------------------
`default_nettype none

module msep_checker
  import msep_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [TimeW-1:0]    cfg_data_i,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // Only one item is in flight: after an accept the input side closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is still in work");

  // No result can appear in the cycle right after its item was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared too early");

  // The contact side is -1, 0 or +1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'b10))
    else $error("invalid contact side");

  // Without a contact side the saved intervals read zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:1] == SideNone)) |-> (m_axis_tdata[193:66] == '0))
    else $error("hit intervals set without a contact side");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind moving_interval_separation_test_core msep_checker u_msep_checker (.*);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the moving interval separation test core.
// ----------------------------------------------------------------------------
// A clocked driver feeds candidate axes from a queue of pending items and
// predicts the pair state after each accepted item. A clocked monitor
// compares every result item field by field with the oldest prediction.
// A short directed part covers the extremes and the special cases. Random
// pairs of axes then follow, mostly well formed with random content, under
// several horizon settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------

module testbench;
  import msep_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned ItemTarget  = 1000;

  typedef struct {
    bit                 new_pair;
    logic signed [QW-1:0] a_min;
    logic signed [QW-1:0] a_max;
    logic signed [QW-1:0] b_min;
    logic signed [QW-1:0] b_max;
    logic signed [QW-1:0] speed;
  } axis_t;

  typedef struct {
    bit                   separated;
    logic [1:0]           side;
    logic [TimeW-1:0]     first_time;
    logic [QW-1:0]        last_time;
    logic [3:0][QW-1:0]   hit;
  } contact_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [TimeW-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  moving_interval_separation_test_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  axis_t    pending_axes[$];
  contact_t expected_contacts[$];
  axis_t    cur_axis;
  contact_t got;
  contact_t want;

  // Predicted pair state and horizon
  longint             horizon_q  = longint'(HorizonRst);
  longint             pair_first = 0;
  longint             pair_last  = longint'(QMax);
  logic [1:0]         pair_side  = SideNone;
  logic [3:0][QW-1:0] pair_hit   = '0;
  bit                 pair_sep   = 1'b0;

  int unsigned n_sent     = 0;
  int unsigned n_tested   = 0;
  int unsigned n_results  = 0;
  int unsigned n_sep      = 0;
  int unsigned n_errors   = 0;
  int unsigned n_settings = 0;
  int unsigned n_cycles   = 0;
  int unsigned src_wait   = 0;
  int unsigned sink_wait  = 0;
  int          k;
  bit          calm      = 1'b0;
  bit          nxt_valid;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Contact time in Q16.16, truncated toward zero and saturated to 32 bits.
  function automatic longint contact_time(longint num, longint spd);
    longint q;
    q = (num * 65536) / spd;
    if (q > longint'(QMax)) q = longint'(QMax);
    if (q < longint'(QMin)) q = longint'(QMin);
    return q;
  endfunction

  function automatic void raise_first(longint t, logic [1:0] side, axis_t ax);
    if (t > pair_first) begin
      pair_first = t;
      pair_side  = side;
      pair_hit   = {ax.b_max, ax.b_min, ax.a_max, ax.a_min};
    end
  endfunction

  function automatic bit tighten_last(longint t);
    if (t < pair_last) pair_last = t;
    return pair_first > pair_last;
  endfunction

  function automatic bit axis_separates(axis_t ax);
    longint     amin, amax, bmin, bmax, spd;
    msep_kind_e kind;
    amin = $signed(ax.a_min);
    amax = $signed(ax.a_max);
    bmin = $signed(ax.b_min);
    bmax = $signed(ax.b_max);
    spd  = $signed(ax.speed);
    if (bmax < amin) kind = KIND_LEFT;
    else if (amax < bmin) kind = KIND_RIGHT;
    else kind = KIND_OVER;
    case (kind)
      KIND_LEFT: begin
        if (spd <= 0) return 1'b1;
        raise_first(contact_time(amin - bmin, spd), SideLeft, ax);
        if (pair_first > horizon_q) return 1'b1;
        return tighten_last(contact_time(amax - bmin, spd));
      end
      KIND_RIGHT: begin
        if (spd >= 0) return 1'b1;
        raise_first(contact_time(amax - bmin, spd), SideRight, ax);
        if (pair_first > horizon_q) return 1'b1;
        return tighten_last(contact_time(amin - bmax, spd));
      end
      default: begin
        if (spd > 0) return tighten_last(contact_time(amax - bmin, spd));
        if (spd < 0) return tighten_last(contact_time(amin - bmax, spd));
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void predict_contact(axis_t ax);
    contact_t r;
    if (ax.new_pair) begin
      pair_first = 0;
      pair_last  = longint'(QMax);
      pair_side  = SideNone;
      pair_hit   = '0;
      pair_sep   = 1'b0;
    end
    // A pair already known to be separated ignores further axes.
    if (!pair_sep) begin
      n_tested++;
      if (axis_separates(ax)) pair_sep = 1'b1;
    end
    r.separated  = pair_sep;
    r.side       = pair_side;
    r.first_time = pair_first[TimeW-1:0];
    r.last_time  = pair_last[QW-1:0];
    r.hit        = (pair_side == SideNone) ? '0 : pair_hit;
    expected_contacts.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint got_v, longint want_v);
    if (n_errors < 30)
      $display("Mismatch on result %0d, %s: got %0h, expected %0h",
               n_results, what, got_v, want_v);
    n_errors++;
  endtask

  task automatic queue_axis(bit np, longint amin, longint amax, longint bmin,
                            longint bmax, longint spd);
    axis_t ax;
    ax.new_pair = np;
    ax.a_min    = amin[QW-1:0];
    ax.a_max    = amax[QW-1:0];
    ax.b_min    = bmin[QW-1:0];
    ax.b_max    = bmax[QW-1:0];
    ax.speed    = spd[QW-1:0];
    pending_axes.push_back(ax);
  endtask

  task automatic queue_random_axis(bit first_of_pair);
    longint      base, wa, wb, gap, spd, t, amin, amax, bmin, bmax, sv;
    int unsigned pick;
    pick = $urandom_range(0, 15);
    base = longint'($urandom_range(0, 32'h2000_0000)) - 64'sh1000_0000;
    wa = longint'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 32'h0800_0000
                                                                : 32'h0010_0000));
    wb = longint'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 32'h0800_0000
                                                                : 32'h0010_0000));
    case ($urandom_range(0, 3))
      0:       spd = longint'($urandom_range(1, 255));
      1:       spd = longint'($urandom_range(256, 65535));
      2:       spd = longint'($urandom_range(65536, 32'h00FF_FFFF));
      default: spd = longint'($urandom_range(32'h0100_0000, 32'h7FFF_FFFF));
    endcase
    // Aim first contact around the horizon, sometimes past it.
    t   = horizon_q * longint'($urandom_range(0, 5)) / 4;
    gap = t * spd / 65536;
    if (gap > 64'sh0800_0000) gap = 64'sh0800_0000;
    amin = base;
    amax = base + wa;
    if (pick < 2) begin
      queue_axis(first_of_pair | bit'($urandom_range(0, 1)), longint'($urandom()),
                 longint'($urandom()), longint'($urandom()), longint'($urandom()),
                 longint'($urandom()));
      return;
    end else if (pick < 6) begin
      bmin = base - wb / 2 + longint'($urandom_range(0, wa[31:0]));
      bmax = bmin + wb;
      case ($urandom_range(0, 4))
        0:       sv = 0;
        1, 2:    sv = spd;
        default: sv = -spd;
      endcase
    end else if (pick < 10) begin
      bmax = base - 1 - gap;
      bmin = bmax - wb;
      sv   = spd;
    end else if (pick < 14) begin
      bmin = amax + 1 + gap;
      bmax = bmin + wb;
      sv   = -spd;
    end else begin
      bmax = base - 1 - gap;
      bmin = bmax - wb;
      sv   = ($urandom_range(0, 1) == 0) ? 0 : -spd;
    end
    if ($urandom_range(0, 15) == 0) begin
      t    = amin;
      amin = amax;
      amax = t;
    end
    queue_axis(first_of_pair, amin, amax, bmin, bmax, sv);
  endtask

  task automatic write_horizon(logic [TimeW-1:0] value);
    @(posedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    horizon_q = longint'(value);
    n_settings++;
  endtask

  // Holds the sender until every predicted result has come back.
  task automatic settle();
    while (pending_axes.size() != 0 || s_axis_tvalid || expected_contacts.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Driver: presents pending items, predicts each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_wait = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_contact(cur_axis);
        n_sent++;
        nxt_valid = 1'b0;
        src_wait  = calm ? 0 : $urandom_range(0, 4);
      end
      if (!nxt_valid) begin
        if (src_wait != 0) begin
          if (s_axis_tready || $urandom_range(0, 3) == 0) src_wait--;
        end else if (pending_axes.size() != 0) begin
          cur_axis = pending_axes.pop_front();
          s_axis_tdata <= {cur_axis.speed, cur_axis.b_max, cur_axis.b_min,
                           cur_axis.a_max, cur_axis.a_min};
          s_axis_tuser <= cur_axis.new_pair;
          nxt_valid = 1'b1;
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // Monitor: checks each result item against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.separated  = m_axis_tdata[0];
        got.side       = m_axis_tdata[2:1];
        got.first_time = m_axis_tdata[33:3];
        got.last_time  = m_axis_tdata[65:34];
        for (k = 0; k < 4; k++) got.hit[k] = m_axis_tdata[66 + 32 * k +: 32];
        if (expected_contacts.size() == 0) begin
          report_mismatch("result with none pending", 0, 0);
        end else begin
          want = expected_contacts.pop_front();
          if (got.separated != want.separated)
            report_mismatch("separated", got.separated, want.separated);
          if (got.side != want.side)
            report_mismatch("contact_side", got.side, want.side);
          if (got.first_time != want.first_time)
            report_mismatch("first_time", got.first_time, want.first_time);
          if (got.last_time != want.last_time)
            report_mismatch("last_time", got.last_time, want.last_time);
          for (k = 0; k < 4; k++)
            if (got.hit[k] != want.hit[k])
              report_mismatch($sformatf("hit interval %0d", k), got.hit[k], want.hit[k]);
        end
        if (got.separated) n_sep++;
        n_results++;
        sink_wait = calm ? 0 : $urandom_range(0, 4);
      end else if (sink_wait != 0 && (m_axis_tvalid || $urandom_range(0, 7) == 0)) begin
        sink_wait--;
      end
      m_axis_tready <= (sink_wait == 0);
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results pending",
               n_cycles, expected_contacts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [TimeW-1:0] hz;
    int unsigned      n_axes;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);

    // Directed part at the reset horizon.
    queue_axis(1, 0, 0, 0, 0, 0);
    queue_axis(0, -65536, 65536, 0, 131072, 0);
    queue_axis(0, -65536, 65536, 0, 131072, 4000000);
    queue_axis(0, -65536, 65536, 0, 131072, -4000000);
    queue_axis(1, 65536, 131072, -65536, 65000, 32'sh1000_0000);
    queue_axis(0, -131072, -65536, -60000, 0, -32'sh1000_0000);
    queue_axis(0, 65536, 131072, -65536, 65000, -5);
    queue_axis(0, 1, 2, 3, 4, 5);
    queue_axis(1, 0, 10, 100, 200, 0);
    queue_axis(1, 655360, 700000, 0, 100, 65536);
    // Last contact set early, then a later first contact overtakes it.
    queue_axis(1, 0, 1000, 990, 2000, 65536);
    queue_axis(0, 500, 600, 0, 100, 65536);
    queue_axis(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1);
    queue_axis(1, 10, -10, -5, 5, 65536);
    queue_axis(1, 0, 100, 200, 300, 32'sh8000_0000);
    queue_axis(1, -1, -1, -1, -1, -1);
    queue_axis(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh7FFF_FFFF);
    settle();

    // Directed part at the widest horizon: saturation both ways.
    write_horizon(31'h7FFF_FFFF);
    @(negedge clk_i);
    queue_axis(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1);
    queue_axis(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFF0, 32'sh7FFF_FFF0, 1);
    queue_axis(1, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -1);
    queue_axis(0, 65536, 131072, -65536, 65000, 32'sh1000_0000);
    settle();

    while (n_sent < ItemTarget) begin
      case (n_settings % 6)
        0:       hz = '0;
        1:       hz = 31'h7FFF_FFFF;
        2:       hz = 31'd65536;
        3:       hz = TimeW'($urandom_range(0, 32'h0010_0000));
        4:       hz = TimeW'($urandom());
        default: hz = HorizonRst;
      endcase
      write_horizon(hz);
      calm = ($urandom_range(0, 3) == 0);
      @(negedge clk_i);
      repeat (25) begin
        n_axes = $urandom_range(1, 6);
        for (int i = 0; i < n_axes; i++) queue_random_axis(i == 0);
      end
      settle();
    end

    $display("Checked %0d results from %0d axis items, %0d tested and the rest held",
             n_results, n_sent, n_tested);
    $display("on separated pairs; %0d horizon writes, %0d results flagged separated.",
             n_settings, n_sep);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ moving_interval_separation_test_core.f @@
design/msep_pkg.sv
design/msep_div.sv
design/moving_interval_separation_test_core.sv
design/msep_checker.sv
bench/testbench.sv
